FILE: rtl/core/numeric_literal_classifier_assert.svh
// Assertion helpers for the checker file of this block.
`ifndef NUMERIC_LITERAL_CLASSIFIER_ASSERT_SVH
`define NUMERIC_LITERAL_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define NLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("numeric_literal_classifier: check failed");

// Next-cycle implication, disabled while reset is low.
`define NLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("numeric_literal_classifier: check failed");

`endif

FILE: rtl/core/nlc_pkg.sv
`default_nettype none

package nlc_pkg;

    typedef enum logic [2:0] {
        TT_CHAR    = 3'd0,
        TT_INT     = 3'd1,
        TT_DOUBLE  = 3'd2,
        TT_FLOAT   = 3'd3,
        TT_SPECIAL = 3'd4,
        TT_UNKNOWN = 3'd5
    } t_token_type;

    localparam int NUM_WORDS = 6;
    localparam int POS_W     = 3;
    localparam int DATA_W    = 8;

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Length of each special word: nan, nanf, +inf, -inf, +inff, -inff.
    function automatic logic [POS_W-1:0] word_len(input int k);
        logic [POS_W-1:0] len;
        unique case (k)
            0:       len = 3'd3;
            1, 2, 3: len = 3'd4;
            default: len = 3'd5;
        endcase
        return len;
    endfunction

    // Character of special word k at position p; zero past the word's end.
    function automatic logic [7:0] word_char(input int k, input logic [POS_W-1:0] p);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (p)
            3'd0: begin
                if (k <= 1)
                    ch = 8'h6E;
                else if (k == 2 || k == 4)
                    ch = CH_PLUS;
                else
                    ch = CH_MINUS;
            end
            3'd1: ch = (k <= 1) ? 8'h61 : 8'h69;
            3'd2: ch = 8'h6E;
            3'd3: ch = (k == 0) ? 8'h00 : CH_F;
            3'd4: ch = (k >= 4) ? CH_F : 8'h00;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/numeric_literal_classifier.sv
// Numeric literal classifier.
// The slave stream carries a token one character per request: tdata is the
// character, tlast marks the last character and tuser marks an empty token
// (tdata and tlast are then ignored). The master stream carries one type code
// per token in tdata[2:0]: char, int, double, float, special or unknown.
// An empty-token request answers unknown and drops any partial token.
// Each accepted character updates a small set of flag registers; on the last
// character the class is decided in the same cycle and captured in the
// output register, so the result is valid in the cycle after the last request.
// Throughput is one character per cycle unless a held result stalls the input, set by the single flag update path.
// The output register decouples the two sides: a new request is taken while
// the result is read in the same cycle. When the receiver stalls with a
// result held, the input stalls as well, and tdata stays stable.
// Reset clears the flags to the start of a token and empties the output.
`default_nettype none

module numeric_literal_classifier (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,  // [7:0] char_byte
    input  wire logic       i_s_axis_tlast,  // last_char
    input  wire logic       i_s_axis_tuser,  // [0] empty_token
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata   // [2:0] token_type, [7:3] zero
);

    localparam int PW = nlc_pkg::POS_W;
    localparam int NW = nlc_pkg::NUM_WORDS;

    logic [PW-1:0] r_pos, n_pos;
    logic          r_first_nondigit, n_first_nondigit;
    logic [1:0]    r_quote, n_quote;
    logic          r_int_ok, n_int_ok;
    logic          r_dbl_ok, n_dbl_ok;
    logic          r_flt_ok, n_flt_ok;
    logic          r_point, n_point;
    logic          r_suffix_f, n_suffix_f;
    logic [NW-1:0] r_special, n_special;

    logic                 r_out_valid;
    nlc_pkg::t_token_type r_out_type;
    nlc_pkg::t_token_type n_type;

    logic       accept;
    logic       token_end;
    logic [7:0] ch;
    logic       is_digit;
    logic       is_sign;

    function automatic nlc_pkg::t_token_type classify(
        input logic [PW-1:0] n,
        input logic          first_nondigit,
        input logic [1:0]    quote,
        input logic          int_ok,
        input logic          dbl_ok,
        input logic          flt_ok,
        input logic          point,
        input logic [NW-1:0] special
    );
        nlc_pkg::t_token_type t;
        logic                 spec_hit;
        spec_hit = 1'b0;
        for (int k = 0; k < NW; k++) begin
            if (special[k] && n == nlc_pkg::word_len(k))
                spec_hit = 1'b1;
        end
        priority if ((n == 3'd1 && first_nondigit) || (n == 3'd3 && quote == 2'b11))
            t = nlc_pkg::TT_CHAR;
        else if (n != '0 && int_ok)
            t = nlc_pkg::TT_INT;
        else if (n != '0 && dbl_ok && point)
            t = nlc_pkg::TT_DOUBLE;
        else if (n != '0 && flt_ok && point)
            t = nlc_pkg::TT_FLOAT;
        else if (spec_hit)
            t = nlc_pkg::TT_SPECIAL;
        else
            t = nlc_pkg::TT_UNKNOWN;
        return t;
    endfunction

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign token_end       = i_s_axis_tuser || i_s_axis_tlast;
    assign ch              = i_s_axis_tdata;
    assign is_digit        = (ch >= nlc_pkg::CH_ZERO) && (ch <= nlc_pkg::CH_NINE);
    assign is_sign         = (ch == nlc_pkg::CH_PLUS) || (ch == nlc_pkg::CH_MINUS);

    always_comb begin
        n_pos            = r_pos;
        n_first_nondigit = r_first_nondigit;
        n_quote          = r_quote;
        n_int_ok         = r_int_ok;
        n_dbl_ok         = r_dbl_ok;
        n_flt_ok         = r_flt_ok;
        n_point          = r_point;
        n_suffix_f       = r_suffix_f;
        n_special        = r_special;

        if (r_pos == '0) begin
            n_first_nondigit = !is_digit;
            if (ch == nlc_pkg::CH_QUOTE)
                n_quote[0] = 1'b1;
        end
        if (r_pos == 3'd2 && ch == nlc_pkg::CH_QUOTE)
            n_quote[1] = 1'b1;

        // Anything after an f suffix rules out float.
        if (r_suffix_f)
            n_flt_ok = 1'b0;

        priority if (r_pos == '0 && is_sign) begin
        end else if (is_digit) begin
        end else if (ch == nlc_pkg::CH_POINT) begin
            n_int_ok = 1'b0;
            if (r_point) begin
                n_dbl_ok = 1'b0;
                n_flt_ok = 1'b0;
            end
            n_point = 1'b1;
        end else if (ch == nlc_pkg::CH_F) begin
            n_int_ok   = 1'b0;
            n_dbl_ok   = 1'b0;
            n_suffix_f = 1'b1;
        end else begin
            n_int_ok = 1'b0;
            n_dbl_ok = 1'b0;
            n_flt_ok = 1'b0;
        end

        for (int k = 0; k < NW; k++) begin
            if (r_pos >= nlc_pkg::word_len(k) || nlc_pkg::word_char(k, r_pos) != ch)
                n_special[k] = 1'b0;
        end

        n_pos = (r_pos == '1) ? r_pos : r_pos + 1'b1;

        if (i_s_axis_tuser)
            n_type = nlc_pkg::TT_UNKNOWN;
        else
            n_type = classify(n_pos, n_first_nondigit, n_quote, n_int_ok,
                              n_dbl_ok, n_flt_ok, n_point, n_special);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && token_end)) begin
            r_pos            <= '0;
            r_first_nondigit <= 1'b0;
            r_quote          <= '0;
            r_int_ok         <= 1'b1;
            r_dbl_ok         <= 1'b1;
            r_flt_ok         <= 1'b1;
            r_point          <= 1'b0;
            r_suffix_f       <= 1'b0;
            r_special        <= '1;
        end else if (accept) begin
            r_pos            <= n_pos;
            r_first_nondigit <= n_first_nondigit;
            r_quote          <= n_quote;
            r_int_ok         <= n_int_ok;
            r_dbl_ok         <= n_dbl_ok;
            r_flt_ok         <= n_flt_ok;
            r_point          <= n_point;
            r_suffix_f       <= n_suffix_f;
            r_special        <= n_special;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && token_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && token_end) begin
            r_out_type <= n_type;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_type};

endmodule

`default_nettype wire

FILE: rtl/core/nlc_checker.sv
`default_nettype none
`include "numeric_literal_classifier_assert.svh"

module nlc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_axis_tvalid,
    input wire logic       o_s_axis_tready,
    input wire logic [7:0] i_s_axis_tdata,
    input wire logic       i_s_axis_tlast,
    input wire logic       i_s_axis_tuser,
    input wire logic       o_m_axis_tvalid,
    input wire logic       i_m_axis_tready,
    input wire logic [7:0] o_m_axis_tdata
);

    logic in_acc;
    logic in_mid;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign in_mid = in_acc && !i_s_axis_tlast && !i_s_axis_tuser;

    // A held result stays put until it is taken.
    `NLC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // An empty-token request answers unknown on the next cycle.
    `NLC_ASSERT_NEXT(a_empty_unknown, i_clk, i_rst_n, in_acc && i_s_axis_tuser, o_m_axis_tvalid && o_m_axis_tdata[2:0] == nlc_pkg::TT_UNKNOWN)

    // A character inside a token produces no result of its own.
    `NLC_ASSERT_NEXT(a_mid_silent, i_clk, i_rst_n, in_mid && !o_m_axis_tvalid, !o_m_axis_tvalid)

    // With the output empty the input side is never stalled.
    `NLC_ASSERT_NOW(a_ready_idle, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready)

    // Results carry a defined code and zero padding.
    `NLC_ASSERT_NOW(a_code_range, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[7:3] == 5'b0 && o_m_axis_tdata[2:0] != 3'd6 && o_m_axis_tdata[2:0] != 3'd7)

    logic unused_data;
    assign unused_data = ^i_s_axis_tdata;

endmodule

bind numeric_literal_classifier nlc_checker u_nlc_checker (.*);

`default_nettype wire

FILE: dv/numeric_literal_classifier_test.sv
`default_nettype none

module numeric_literal_classifier_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] t_chars[$];

    // Holds the expected type codes and a private copy of the token flags.
    class t_literal_scoreboard;
        string                special_words[6];
        logic [2:0]           pos_cnt;
        bit                   lead_nondigit;
        bit [1:0]             quote_flags;
        bit                   int_ok;
        bit                   dbl_ok;
        bit                   flt_ok;
        bit                   point_seen;
        bit                   f_seen;
        bit [5:0]             word_hits;
        nlc_pkg::t_token_type expected_types[$];
        int                   errors;
        int                   type_counts[6];

        function new();
            special_words = '{"nan", "nanf", "+inf", "-inf", "+inff", "-inff"};
            errors = 0;
            foreach (type_counts[i])
                type_counts[i] = 0;
            clear_token();
        endfunction

        function void clear_token();
            pos_cnt       = 3'd0;
            lead_nondigit = 1'b0;
            quote_flags   = 2'b00;
            int_ok        = 1'b1;
            dbl_ok        = 1'b1;
            flt_ok        = 1'b1;
            point_seen    = 1'b0;
            f_seen        = 1'b0;
            word_hits     = 6'h3F;
        endfunction

        function nlc_pkg::t_token_type decide_type();
            if ((pos_cnt == 3'd1 && lead_nondigit) ||
                (pos_cnt == 3'd3 && quote_flags == 2'b11))
                return nlc_pkg::TT_CHAR;
            if (pos_cnt != 3'd0 && int_ok)
                return nlc_pkg::TT_INT;
            if (pos_cnt != 3'd0 && dbl_ok && point_seen)
                return nlc_pkg::TT_DOUBLE;
            if (pos_cnt != 3'd0 && flt_ok && point_seen)
                return nlc_pkg::TT_FLOAT;
            for (int k = 0; k < 6; k++) begin
                if (word_hits[k] && int'(pos_cnt) == special_words[k].len())
                    return nlc_pkg::TT_SPECIAL;
            end
            return nlc_pkg::TT_UNKNOWN;
        endfunction

        function void note_request(logic [7:0] c, bit last, bit empty);
            int p;
            bit digit;
            if (empty) begin
                clear_token();
                expected_types.push_back(nlc_pkg::TT_UNKNOWN);
                return;
            end
            p = pos_cnt;
            digit = (c >= nlc_pkg::CH_ZERO && c <= nlc_pkg::CH_NINE);
            if (p == 0) begin
                lead_nondigit = !digit;
                if (c == nlc_pkg::CH_QUOTE)
                    quote_flags[0] = 1'b1;
            end
            if (p == 2 && c == nlc_pkg::CH_QUOTE)
                quote_flags[1] = 1'b1;
            // Anything after an f suffix rules out a float.
            if (f_seen)
                flt_ok = 1'b0;
            if (p == 0 && (c == nlc_pkg::CH_PLUS || c == nlc_pkg::CH_MINUS)) begin
            end else if (digit) begin
            end else if (c == nlc_pkg::CH_POINT) begin
                int_ok = 1'b0;
                if (point_seen) begin
                    dbl_ok = 1'b0;
                    flt_ok = 1'b0;
                end
                point_seen = 1'b1;
            end else if (c == nlc_pkg::CH_F) begin
                int_ok = 1'b0;
                dbl_ok = 1'b0;
                f_seen = 1'b1;
            end else begin
                int_ok = 1'b0;
                dbl_ok = 1'b0;
                flt_ok = 1'b0;
            end
            for (int k = 0; k < 6; k++) begin
                if (p >= special_words[k].len() || 8'(special_words[k][p]) != c)
                    word_hits[k] = 1'b0;
            end
            pos_cnt = (pos_cnt == 3'd7) ? 3'd7 : pos_cnt + 3'd1;
            if (last) begin
                expected_types.push_back(decide_type());
                clear_token();
            end
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [7:0] data);
            nlc_pkg::t_token_type want;
            if (expected_types.size() == 0) begin
                report_mismatch($sformatf("type code %0h with no token pending", data));
                return;
            end
            want = expected_types.pop_front();
            if (data[2:0] !== want)
                report_mismatch($sformatf("token type %0d, expected %0d (%s)",
                                          data[2:0], want, want.name()));
            if (data[7:3] !== 5'd0)
                report_mismatch($sformatf("padding bits %b are not zero", data[7:3]));
            type_counts[int'(want)]++;
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;   // [7:0] char_byte
    logic       i_s_axis_tlast;   // last_char
    logic       i_s_axis_tuser;   // [0] empty_token
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;   // [2:0] token_type, [7:3] zero

    t_literal_scoreboard sb;
    bit                  no_idle;
    int                  items_sent;
    int                  tokens_sent;

    numeric_literal_classifier i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata);
    end

    // Receiver: a fresh stall before each result, none while no_idle is set.
    initial begin
        int stall;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    task automatic send_request(input logic [7:0] c, input bit last, input bit empty);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tlast  <= last;
        i_s_axis_tuser  <= empty;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_request(c, last, empty);
        items_sent++;
    endtask

    // With close set the last character carries tlast; otherwise the
    // partial token is dropped by an empty-token request.
    task automatic send_chars(input t_chars tok, input bit close);
        foreach (tok[i])
            send_request(tok[i], close && (i == tok.size() - 1), 1'b0);
        if (!close)
            send_empty();
        tokens_sent++;
    endtask

    task automatic send_empty();
        send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic send_text(input string s);
        t_chars tok;
        for (int i = 0; i < s.len(); i++)
            tok.push_back(s[i]);
        send_chars(tok, 1'b1);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_types.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] any_digit();
        return nlc_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] any_sign();
        return $urandom_range(0, 1) ? nlc_pkg::CH_PLUS : nlc_pkg::CH_MINUS;
    endfunction

    // Mostly well-formed literals of each class with random content, some
    // broken on purpose, plus raw noise. An empty queue stands for an
    // empty-token request.
    function automatic t_chars random_token();
        t_chars tok;
        string  alpha;
        int     n;
        int     k;
        alpha = "+-.f'0123456789nai";
        case ($urandom_range(0, 11))
            0, 1: begin
                if ($urandom_range(0, 1))
                    tok.push_back(any_sign());
                n = $urandom_range(1, 9);
                repeat (n) tok.push_back(any_digit());
            end
            2, 3, 4, 5: begin
                if ($urandom_range(0, 1))
                    tok.push_back(any_sign());
                n = $urandom_range(0, 4);
                repeat (n) tok.push_back(any_digit());
                tok.insert(tok.size() - $urandom_range(0, n), nlc_pkg::CH_POINT);
                if ($urandom_range(0, 5) == 0)
                    tok.insert($urandom_range(0, tok.size()), nlc_pkg::CH_POINT);
                if ($urandom_range(0, 1)) begin
                    tok.push_back(nlc_pkg::CH_F);
                    if ($urandom_range(0, 4) == 0)
                        tok.push_back(any_digit());
                end
            end
            6, 7: begin
                k = $urandom_range(0, 5);
                for (int i = 0; i < sb.special_words[k].len(); i++)
                    tok.push_back(sb.special_words[k][i]);
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 2))
                        0: tok.pop_back();
                        1: tok.push_back(nlc_pkg::CH_F);
                        default: tok[$urandom_range(0, tok.size() - 1)] =
                                     8'($urandom_range(0, 255));
                    endcase
                end
            end
            8: begin
                n = $urandom_range(0, 2);
                tok.push_back(n == 0 ? 8'($urandom_range(0, 255)) : nlc_pkg::CH_QUOTE);
                if (n != 0) begin
                    tok.push_back(8'($urandom_range(0, 255)));
                    tok.push_back(n == 1 ? nlc_pkg::CH_QUOTE : 8'($urandom_range(0, 255)));
                end
            end
            9: begin
                n = $urandom_range(1, 10);
                repeat (n) tok.push_back(8'($urandom_range(0, 255)));
            end
            10: begin
                n = $urandom_range(1, 9);
                repeat (n) tok.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
            end
            default: begin
            end
        endcase
        return tok;
    endfunction

    initial begin
        t_chars tok;
        bit     paused;
        sb              = new();
        no_idle         = 1'b0;
        items_sent      = 0;
        tokens_sent     = 0;
        paused          = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_s_axis_tlast  = 1'b0;
        i_s_axis_tuser  = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed tokens: empty, a lone digit, the byte extremes, a quoted
        // char, a signed float without leading digit, the longest special
        // word, a bare trailing point and a token cut short by an empty.
        send_empty();
        send_text("7");
        send_chars('{8'hFF}, 1'b1);
        send_text("'a'");
        send_text("-.5f");
        send_text("+inff");
        send_text("1.");
        send_chars('{8'h6E, 8'h61}, 1'b0);
        send_chars('{8'h00}, 1'b1);
        send_text("+.");

        while (items_sent < 490) begin
            if ($urandom_range(0, 24) == 0)
                no_idle = !no_idle;
            if (!paused && items_sent >= 250) begin
                wait_drained();
                paused = 1'b1;
            end
            tok = random_token();
            if (tok.size() == 0)
                send_empty();
            else
                send_chars(tok, $urandom_range(0, 9) != 0);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d characters in %0d tokens, with and without idle cycles.",
                 items_sent, tokens_sent);
        $display("Checked types: char %0d, int %0d, double %0d, float %0d,",
                 sb.type_counts[0], sb.type_counts[1], sb.type_counts[2],
                 sb.type_counts[3]);
        $display("               special %0d, unknown %0d.",
                 sb.type_counts[4], sb.type_counts[5]);
        if (sb.errors == 0 && sb.expected_types.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/nlc_pkg.sv
rtl/core/numeric_literal_classifier.sv
rtl/core/nlc_checker.sv
dv/numeric_literal_classifier_test.sv
